@@ hdl/lzwd_pkg.sv @@
package lzwd_pkg;

    // decoder phase
    typedef enum logic [3:0] {
        PH_TYPE,
        PH_SIZE0,
        PH_SIZE1,
        PH_SIZE2,
        PH_TOKEN,
        PH_MATCH_LO,
        PH_DRAIN,
        PH_COPY_START,
        PH_COPY
    } phase_t;

    typedef logic [2:0] status_t;

    // result status codes
    localparam status_t ST_DATA     = 3'd0;
    localparam status_t ST_EMPTY    = 3'd1;
    localparam status_t ST_BAD_DIST = 3'd2;
    localparam status_t ST_OVERRUN  = 3'd3;
    localparam status_t ST_SHORT    = 3'd4;
    localparam status_t ST_BAD_TYPE = 3'd5;

    // stream format constants
    localparam logic [7:0] TYPE_LZ10 = 8'h10;
    localparam int         MIN_MATCH = 3;
    localparam int         LEN_BITS  = 5;
    localparam int         DIST_BITS = 13;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       out_last;
    } res_t;

endpackage

@@ hdl/lzwd_ifs.sv @@
interface lzwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzwd_out_if;
    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    lzwd_pkg::status_t status;
    logic             out_last;

    modport source (output valid, output out_byte, output status, output out_last,
                    input ready);
    modport sink (input valid, input out_byte, input status, input out_last,
                  output ready);
endinterface

@@ hdl/lzss_window_decompressor.sv @@
// LZ10 style LZSS decompressor with a WINDOW_DEPTH byte history memory.
// din carries the compressed file one byte per transaction (in_last marks the
// final byte). dout carries one decoded byte per transaction with status 0,
// or a single status result (empty, bad distance, overrun, short input, bad
// type) with out_last set; the data byte that completes the size also has
// out_last set. After an error the rest of the stream is dropped up to the
// byte marked last.
// Timing: header, flag and literal bytes are taken one per cycle while din is
// ready; a literal appears on dout in the cycle after its transaction. A match
// token takes its two bytes, then a start state issues the first history read,
// then one byte is emitted per cycle while dout is not stalled. The copy rate
// is set by the single read port of the history memory; a one-entry forward
// covers a read of the byte written just before. A stalled dout holds the
// result register and freezes the copy; din is accepted only when the result
// register is free or being emptied and no match copy is running.
// Reset clears all control state and returns to waiting for the type byte;
// the history memory is not cleared, as only bytes of the current stream
// are ever read.
module lzss_window_decompressor #(
    parameter int WINDOW_DEPTH = 4096,
    parameter int SIZE_BITS    = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    lzwd_in_if.sink     din,
    lzwd_out_if.source  dout
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [31:0] SIZE_MAX = 32'((64'd1 << SIZE_BITS) - 64'd1);
    localparam logic [AW:0] DEPTH_EXT = (AW+1)'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);
    localparam int LEN_BITS_W = lzwd_pkg::LEN_BITS;

    lzwd_pkg::phase_t phase_reg, phase_next;
    logic [SIZE_BITS-1:0] prod_reg, prod_next;
    logic [SIZE_BITS-1:0] target_reg, target_next;
    logic [15:0] size_lo_reg, size_lo_next;
    logic [7:0] flags_reg, flags_next;
    logic [3:0] fpos_reg, fpos_next;
    logic [7:0] mhigh_reg, mhigh_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] src_reg, src_next;
    logic [LEN_BITS_W-1:0] cnt_reg, cnt_next;
    logic tlast_reg, tlast_next;
    logic out_valid_reg, out_valid_next;
    lzwd_pkg::res_t out_res_reg, out_res_next;

    // history memory signals
    logic [7:0] hist_mem [WINDOW_DEPTH];
    logic [7:0] rd_data_reg;
    logic fwd_reg;
    logic [7:0] fwd_data_reg;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [7:0] hist_byte;

    logic slot_free;
    logic accept;
    logic advance;
    logic [SIZE_BITS:0] prod_inc;
    logic [SIZE_BITS:0] prod_len;
    logic [SIZE_BITS:0] target_ext;
    logic [31:0] hdr_size;
    logic [31:0] sat_size;
    logic [15:0] code;
    logic [LEN_BITS_W-1:0] mlen;
    logic [lzwd_pkg::DIST_BITS-1:0] mdist;
    logic [AW:0] ptr_ext;
    logic [AW:0] dist_ext;
    logic [AW:0] src_calc;
    logic [AW-1:0] wptr_inc;

    // handshake
    assign slot_free = !out_valid_reg || dout.ready;
    assign din.ready = slot_free && (phase_reg != lzwd_pkg::PH_COPY_START)
                       && (phase_reg != lzwd_pkg::PH_COPY);
    assign accept = din.valid && din.ready;
    assign advance = (phase_reg == lzwd_pkg::PH_COPY) && slot_free;

    assign dout.valid    = out_valid_reg;
    assign dout.out_byte = out_res_reg.out_byte;
    assign dout.status   = out_res_reg.status;
    assign dout.out_last = out_res_reg.out_last;

    // shared arithmetic
    assign prod_inc   = {1'b0, prod_reg} + 1'b1;
    assign target_ext = {1'b0, target_reg};
    assign code       = {mhigh_reg, din.in_byte};
    assign mlen       = LEN_BITS_W'(code[15:12]) + LEN_BITS_W'(lzwd_pkg::MIN_MATCH);
    assign mdist      = {1'b0, code[11:0]} + 1'b1;
    assign prod_len   = {1'b0, prod_reg} + (SIZE_BITS+1)'(mlen);
    assign hdr_size   = {8'd0, din.in_byte, size_lo_reg};
    assign sat_size   = (hdr_size > SIZE_MAX) ? SIZE_MAX : hdr_size;
    assign ptr_ext    = {1'b0, wptr_reg};
    assign dist_ext   = (AW+1)'(mdist);
    assign src_calc   = (ptr_ext >= dist_ext) ? (ptr_ext - dist_ext)
                                              : (ptr_ext + DEPTH_EXT - dist_ext);
    assign wptr_inc   = (wptr_reg == LAST_IDX) ? '0 : wptr_reg + 1'b1;

    // history read with forward of a same-cycle write
    assign hist_byte = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign rd_addr   = advance ? ((src_reg == LAST_IDX) ? '0 : src_reg + 1'b1) : src_reg;
    assign wr_addr   = wptr_reg;

    // next state and outputs
    always_comb
    begin
        phase_next     = phase_reg;
        prod_next      = prod_reg;
        target_next    = target_reg;
        size_lo_next   = size_lo_reg;
        flags_next     = flags_reg;
        fpos_next      = fpos_reg;
        mhigh_next     = mhigh_reg;
        wptr_next      = wptr_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        tlast_next     = tlast_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        out_res_next   = out_res_reg;
        wr_en          = 1'b0;
        wr_data        = din.in_byte;

        unique case (phase_reg)
            lzwd_pkg::PH_TYPE:
            begin
                if (accept)
                begin
                    prod_next    = '0;
                    target_next  = '0;
                    size_lo_next = '0;
                    flags_next   = '0;
                    fpos_next    = '0;
                    mhigh_next   = '0;
                    wptr_next    = '0;
                    if (din.in_byte != lzwd_pkg::TYPE_LZ10)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = '{8'd0, lzwd_pkg::ST_BAD_TYPE, 1'b1};
                        phase_next     = din.in_last ? lzwd_pkg::PH_TYPE
                                                     : lzwd_pkg::PH_DRAIN;
                    end
                    else if (din.in_last)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = '{8'd0, lzwd_pkg::ST_SHORT, 1'b1};
                    end
                    else
                    begin
                        phase_next = lzwd_pkg::PH_SIZE0;
                    end
                end
            end
            lzwd_pkg::PH_SIZE0, lzwd_pkg::PH_SIZE1:
            begin
                if (accept)
                begin
                    if (phase_reg == lzwd_pkg::PH_SIZE0)
                        size_lo_next[7:0] = din.in_byte;
                    else
                        size_lo_next[15:8] = din.in_byte;
                    if (din.in_last)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = '{8'd0, lzwd_pkg::ST_SHORT, 1'b1};
                        phase_next     = lzwd_pkg::PH_TYPE;
                    end
                    else
                    begin
                        phase_next = (phase_reg == lzwd_pkg::PH_SIZE0)
                                     ? lzwd_pkg::PH_SIZE1 : lzwd_pkg::PH_SIZE2;
                    end
                end
            end
            lzwd_pkg::PH_SIZE2:
            begin
                if (accept)
                begin
                    target_next = sat_size[SIZE_BITS-1:0];
                    if (sat_size == 32'd0)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = '{8'd0, lzwd_pkg::ST_EMPTY, 1'b1};
                        phase_next     = din.in_last ? lzwd_pkg::PH_TYPE
                                                     : lzwd_pkg::PH_DRAIN;
                    end
                    else if (din.in_last)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = '{8'd0, lzwd_pkg::ST_SHORT, 1'b1};
                        phase_next     = lzwd_pkg::PH_TYPE;
                    end
                    else
                    begin
                        phase_next = lzwd_pkg::PH_TOKEN;
                    end
                end
            end
            lzwd_pkg::PH_TOKEN:
            begin
                if (accept)
                begin
                    if (fpos_reg == 4'd0)
                    begin
                        // new flag byte
                        flags_next = din.in_byte;
                        fpos_next  = 4'd8;
                        if (din.in_last)
                        begin
                            out_valid_next = 1'b1;
                            out_res_next   = '{8'd0, lzwd_pkg::ST_SHORT, 1'b1};
                            phase_next     = lzwd_pkg::PH_TYPE;
                        end
                    end
                    else
                    begin
                        flags_next = {flags_reg[6:0], 1'b0};
                        fpos_next  = fpos_reg - 1'b1;
                        if (flags_reg[7])
                        begin
                            // first byte of a match token
                            mhigh_next = din.in_byte;
                            if (din.in_last)
                            begin
                                out_valid_next = 1'b1;
                                out_res_next   = '{8'd0, lzwd_pkg::ST_SHORT, 1'b1};
                                phase_next     = lzwd_pkg::PH_TYPE;
                            end
                            else
                            begin
                                phase_next = lzwd_pkg::PH_MATCH_LO;
                            end
                        end
                        else if (din.in_last && (prod_inc != target_ext))
                        begin
                            out_valid_next = 1'b1;
                            out_res_next   = '{8'd0, lzwd_pkg::ST_SHORT, 1'b1};
                            phase_next     = lzwd_pkg::PH_TYPE;
                        end
                        else
                        begin
                            // literal byte
                            wr_en          = 1'b1;
                            wptr_next      = wptr_inc;
                            prod_next      = prod_inc[SIZE_BITS-1:0];
                            out_valid_next = 1'b1;
                            out_res_next   = '{din.in_byte, lzwd_pkg::ST_DATA,
                                               prod_inc == target_ext};
                            if (prod_inc == target_ext)
                                phase_next = din.in_last ? lzwd_pkg::PH_TYPE
                                                         : lzwd_pkg::PH_DRAIN;
                        end
                    end
                end
            end
            lzwd_pkg::PH_MATCH_LO:
            begin
                if (accept)
                begin
                    phase_next = lzwd_pkg::PH_TOKEN;
                    if (SIZE_BITS'(mdist) > prod_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = '{8'd0, lzwd_pkg::ST_BAD_DIST, 1'b1};
                        phase_next     = din.in_last ? lzwd_pkg::PH_TYPE
                                                     : lzwd_pkg::PH_DRAIN;
                    end
                    else if (prod_len > target_ext)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = '{8'd0, lzwd_pkg::ST_OVERRUN, 1'b1};
                        phase_next     = din.in_last ? lzwd_pkg::PH_TYPE
                                                     : lzwd_pkg::PH_DRAIN;
                    end
                    else if (din.in_last && (prod_len != target_ext))
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = '{8'd0, lzwd_pkg::ST_SHORT, 1'b1};
                        phase_next     = lzwd_pkg::PH_TYPE;
                    end
                    else
                    begin
                        src_next   = src_calc[AW-1:0];
                        cnt_next   = mlen;
                        tlast_next = din.in_last;
                        phase_next = lzwd_pkg::PH_COPY_START;
                    end
                end
            end
            lzwd_pkg::PH_COPY_START:
            begin
                // first history read is issued this cycle
                phase_next = lzwd_pkg::PH_COPY;
            end
            lzwd_pkg::PH_COPY:
            begin
                if (advance)
                begin
                    wr_en          = 1'b1;
                    wr_data        = hist_byte;
                    wptr_next      = wptr_inc;
                    src_next       = rd_addr;
                    prod_next      = prod_inc[SIZE_BITS-1:0];
                    cnt_next       = cnt_reg - 1'b1;
                    out_valid_next = 1'b1;
                    out_res_next   = '{hist_byte, lzwd_pkg::ST_DATA,
                                       prod_inc == target_ext};
                    if (cnt_reg == LEN_BITS_W'(1))
                    begin
                        if (prod_inc == target_ext)
                            phase_next = tlast_reg ? lzwd_pkg::PH_TYPE
                                                   : lzwd_pkg::PH_DRAIN;
                        else
                            phase_next = lzwd_pkg::PH_TOKEN;
                    end
                end
            end
            lzwd_pkg::PH_DRAIN:
            begin
                if (accept && din.in_last)
                    phase_next = lzwd_pkg::PH_TYPE;
            end
            default:
            begin
                if (accept && din.in_last)
                    phase_next = lzwd_pkg::PH_TYPE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lzwd_pkg::PH_TYPE;
            prod_reg      <= '0;
            target_reg    <= '0;
            size_lo_reg   <= '0;
            flags_reg     <= '0;
            fpos_reg      <= '0;
            mhigh_reg     <= '0;
            wptr_reg      <= '0;
            src_reg       <= '0;
            cnt_reg       <= '0;
            tlast_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            prod_reg      <= prod_next;
            target_reg    <= target_next;
            size_lo_reg   <= size_lo_next;
            flags_reg     <= flags_next;
            fpos_reg      <= fpos_next;
            mhigh_reg     <= mhigh_next;
            wptr_reg      <= wptr_next;
            src_reg       <= src_next;
            cnt_reg       <= cnt_next;
            tlast_reg     <= tlast_next;
            out_valid_reg <= out_valid_next;
            fwd_reg       <= wr_en && (wr_addr == rd_addr);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        fwd_data_reg <= wr_data;
    end

    // history memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            hist_mem[wr_addr] <= wr_data;
        rd_data_reg <= hist_mem[rd_addr];
    end

    // checks
    a_copy_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lzwd_pkg::PH_COPY_START |=> phase_reg == lzwd_pkg::PH_COPY)
        else $error("copy did not follow its start cycle");

    a_copy_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lzwd_pkg::PH_COPY |-> cnt_reg != '0)
        else $error("copy running with zero bytes left");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.status != lzwd_pkg::ST_DATA) |-> out_res_reg.out_last)
        else $error("status result without end mark");

    a_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lzwd_pkg::PH_TOKEN |-> prod_reg < target_reg)
        else $error("token phase with size already reached");

endmodule
